// ----- hdl/tlbsf_pkg.sv -----
// shared types, register indexes and color arithmetic for the band shift filter
// used by tlbsf_cell and tape_look_band_shift_filter_core
// no dependencies
package tlbsf_pkg;

	// one BGRA pixel, blue in the lowest byte
	typedef struct packed {
		logic [7:0] alpha;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pix_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_BAND_WIDTH  = 2'd0,
		REG_BAND_PERIOD = 2'd1,
		REG_TINT_LEVEL  = 2'd2,
		REG_GHOST_SHIFT = 2'd3
	} reg_idx_t;

	// sequencer states
	typedef enum logic {
		ST_RUN,
		ST_FLUSH
	} state_t;

	localparam logic [9:0] TINT_BIAS = 10'd127;
	localparam logic [9:0] CHAN_MAX  = 10'd255;

	// average two channel values, then apply the band offset with clamping
	function automatic logic [7:0] tone(input logic [7:0] a, input logic [7:0] b,
			input logic band, input logic [7:0] tint);
		logic [8:0] sum;
		logic [9:0] avg;
		logic signed [9:0] v;
		logic [7:0] res;
		sum = {1'b0, a} + {1'b0, b};
		avg = {2'b00, sum[8:1]};
		v = $signed(avg + {2'b00, tint} - TINT_BIAS);
		res = avg[7:0];
		if (band) begin
			if (v < 0)
				res = 8'd0;
			else if (v > $signed(CHAN_MAX))
				res = 8'hff;
			else
				res = v[7:0];
		end
		return res;
	endfunction

	// all three colors of a pixel, alpha from the front pixel
	function automatic pix_t tone_pix(input pix_t f, input pix_t p, input logic band,
			input logic [7:0] tint);
		pix_t r;
		r.blue  = tone(f.blue, p.blue, band, tint);
		r.green = tone(f.green, p.green, band, tint);
		r.red   = tone(f.red, p.red, band, tint);
		r.alpha = f.alpha;
		return r;
	endfunction

endpackage

// ----- hdl/tlbsf_cell.sv -----
// one cell of the held-pixel row: stores a pixel, takes its right neighbor on a shift
// and drives its pixel onto the partner tap when selected
// depends on tlbsf_pkg
module tlbsf_cell import tlbsf_pkg::*; #(
	parameter int IDX   = 0,
	parameter int IDX_W = 6
) (
	input  logic             clk,
	input  logic             shift_en,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_idx,
	input  logic [IDX_W-1:0] tap_idx,
	input  pix_t             px,
	input  pix_t             nbr,
	output pix_t             q,
	output pix_t             tap
);

	pix_t pix_q;
	logic hit_wr;
	logic hit_tap;

	assign hit_wr  = wr_en && (wr_idx == IDX_W'(IDX));
	assign hit_tap = (tap_idx == IDX_W'(IDX));

	// load new pixel, shift toward the front, or hold
	always_ff @(posedge clk) begin
		if (hit_wr)
			pix_q <= px;
		else if (shift_en)
			pix_q <= nbr;
	end

	assign q   = pix_q;
	assign tap = hit_tap ? pix_q : '0;

endmodule

// ----- hdl/tape_look_band_shift_filter_core.sv -----
// top level of the tape-look band and ghost filter
// depends on tlbsf_pkg and tlbsf_cell

// Each BGRA pixel is averaged in blue, green and red with the pixel ghost_shift places to
// its right in the same row (the row's last pixel stands in past the row end); alpha passes.
// Rows whose index modulo band_period is below band_width get tint_level - 127 added,
// clamped to 0..255. Output lags input by ghost_shift pixels. In the middle of a row the
// block takes one pixel per cycle while the output is drained. A row end (or frame end)
// then flushes the held pixels one per cycle while the output is drained, during which no
// input is taken. After ghost_shift was lowered mid-row, the next pixel releases each
// surplus held pixel at one per cycle while the output is drained, and no input is taken
// until they are out. The figure is set by the single result path of the cell row: one
// result per cycle. Configuration writes are always taken (cfg_ready is high).
module tape_look_band_shift_filter_core import tlbsf_pkg::*; #(
	parameter int MAX_SHIFT = 63
) (
	input  logic        clk,
	input  logic        arst_n,
	// config write: cfg_index selects register
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	// input pixels
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // blue_in, green_in, red_in, alpha_in
	input  logic        s_axis_tlast,  // row_end
	input  logic [0:0]  s_axis_tuser,  // frame_end
	// output pixels
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // blue_out, green_out, red_out, alpha_out
	output logic        m_axis_tlast,  // row_done
	output logic [0:0]  m_axis_tuser   // frame_done
);

	localparam int DEPTH = MAX_SHIFT;
	localparam int IDX_W = $clog2(MAX_SHIFT + 1);

	// configuration registers
	logic [4:0] band_width_q;
	logic [5:0] band_period_q;
	logic [7:0] tint_level_q;
	logic [5:0] ghost_shift_q;

	// control state
	state_t           state_q, state_d;
	logic [IDX_W-1:0] held_q;
	logic [5:0]       row_phase_q;
	logic             band_q;
	logic             fe_q;
	logic             go_q;
	pix_t             last_q;

	// output register
	logic out_vld_q;
	pix_t out_pix_q;
	logic out_last_q;
	logic out_fe_q;

	// datapath and control signals
	pix_t             px;
	pix_t             front;
	pix_t             partner;
	pix_t             tap_or;
	pix_t             cell_q   [DEPTH];
	pix_t             cell_tap [DEPTH];
	logic [IDX_W-1:0] shift;
	logic             advance;
	logic             extra;
	logic             acc;
	logic             in_last;
	logic             emit_acc;
	logic             emit_extra;
	logic             emit_flush;
	logic             emit;
	logic             band_now;
	logic             res_last;
	logic             res_fe;
	logic             wr_en;
	logic [IDX_W-1:0] wr_idx;

	assign px = pix_t'(s_axis_tdata);
	assign cfg_ready = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_width_q  <= 5'd2;
			band_period_q <= 6'd4;
			tint_level_q  <= 8'd100;
			ghost_shift_q <= 6'd3;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_BAND_WIDTH:  band_width_q  <= cfg_data[4:0];
				REG_BAND_PERIOD: band_period_q <= cfg_data[5:0];
				REG_TINT_LEVEL:  tint_level_q  <= cfg_data;
				REG_GHOST_SHIFT: ghost_shift_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// effective shift, limited to the cell row
	assign shift = (32'(ghost_shift_q) > MAX_SHIFT) ? IDX_W'(MAX_SHIFT)
		: ghost_shift_q[IDX_W-1:0];

	// handshake and request qualification
	assign advance       = !out_vld_q || m_axis_tready;
	assign extra         = held_q > shift;
	assign s_axis_tready = (state_q == ST_RUN) && advance && !go_q;
	assign acc           = s_axis_tvalid && s_axis_tready;
	assign in_last       = s_axis_tlast || s_axis_tuser[0];
	assign emit_acc      = acc && (held_q >= shift);
	assign emit_extra    = go_q && advance;
	assign emit_flush    = (state_q == ST_FLUSH) && advance && !go_q;
	assign emit          = emit_acc || emit_extra || emit_flush;

	// cell row control
	assign wr_en  = acc && !(emit_acc && (held_q == '0));
	assign wr_idx = emit_acc ? held_q - 1'b1 : held_q;

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			pix_t nbr;
			if (gi < DEPTH - 1) begin : g_mid
				assign nbr = cell_q[gi+1];
			end else begin : g_end
				assign nbr = cell_q[gi];
			end
			tlbsf_cell #(
				.IDX   (gi),
				.IDX_W (IDX_W)
			) u_cell (
				.clk      (clk),
				.shift_en (emit),
				.wr_en    (wr_en),
				.wr_idx   (wr_idx),
				.tap_idx  (shift),
				.px       (px),
				.nbr      (nbr),
				.q        (cell_q[gi]),
				.tap      (cell_tap[gi])
			);
		end
	endgenerate

	// gather the partner tap from the row
	always_comb begin
		tap_or = '0;
		for (int i = 0; i < DEPTH; i++)
			tap_or = tap_or | cell_tap[i];
	end

	// operands of the result
	always_comb begin
		front = (held_q == '0) ? px : cell_q[0];
		if ((state_q == ST_FLUSH) && !go_q)
			partner = last_q;
		else if (acc && (held_q == shift))
			partner = px;
		else
			partner = tap_or;
		band_now = (state_q == ST_FLUSH) ? band_q : (row_phase_q < {1'b0, band_width_q});
	end

	// run end marks of the result
	always_comb begin
		res_last = 1'b0;
		res_fe   = 1'b0;
		if ((state_q == ST_FLUSH) && (emit_flush || emit_extra) && (held_q == IDX_W'(1))) begin
			res_last = 1'b1;
			res_fe   = fe_q;
		end else if (emit_acc && in_last && (held_q == '0)) begin
			res_last = 1'b1;
			res_fe   = s_axis_tuser[0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_RUN: begin
				if (acc && in_last && !(emit_acc && (held_q == '0)))
					state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				if ((emit_flush || emit_extra) && (held_q == IDX_W'(1)))
					state_d = ST_RUN;
			end
			default: state_d = ST_RUN;
		endcase
	end

	// state, held count, surplus drain and row phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			held_q      <= '0;
			row_phase_q <= '0;
			band_q      <= 1'b0;
			fe_q        <= 1'b0;
			go_q        <= 1'b0;
		end else begin
			state_q <= state_d;
			if (acc && !emit_acc)
				held_q <= held_q + 1'b1;
			else if (emit_extra || emit_flush)
				held_q <= held_q - 1'b1;
			// surplus pixels left by a lowered shift drain after the next input
			if (acc && extra)
				go_q <= 1'b1;
			else if (emit_extra && ((held_q - 1'b1) == shift))
				go_q <= 1'b0;
			if (acc && in_last) begin
				band_q <= row_phase_q < {1'b0, band_width_q};
				fe_q   <= s_axis_tuser[0];
				if (s_axis_tuser[0] || (7'(row_phase_q) + 7'd1 >= 7'(band_period_q)))
					row_phase_q <= '0;
				else
					row_phase_q <= row_phase_q + 6'd1;
			end
		end
	end

	// newest pixel of a row, partner for the flush
	always_ff @(posedge clk) begin
		if (acc)
			last_q <= px;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (advance)
			out_vld_q <= emit;
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_pix_q  <= tone_pix(front, partner, band_now, tint_level_q);
			out_last_q <= res_last;
			out_fe_q   <= res_fe;
		end
	end

	assign m_axis_tvalid   = out_vld_q;
	assign m_axis_tdata    = out_pix_q;
	assign m_axis_tlast    = out_last_q;
	assign m_axis_tuser[0] = out_fe_q;

	// a flush never runs with an empty cell row
	a_flush_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) |-> (held_q != '0))
		else $error("flush with no held pixels");

	// at most one result source per cycle
	a_one_source: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({emit_acc, emit_extra, emit_flush}))
		else $error("two result sources in one cycle");

	// leaving the flush leaves the row empty
	a_flush_drains: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_FLUSH) ##1 (state_q == ST_RUN)) |-> (held_q == '0))
		else $error("pixels left after flush");

	// a run end result only while the row drains to empty
	a_last_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit && res_last) |=> (held_q == '0))
		else $error("row end result with pixels still held");

endmodule
